[hw/rtl/pmau_pkg.sv]
// Shared types and codes for the paged memory access unit.
// No dependencies.
package pmau_pkg;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_XLATE = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_RD    = 7'b0001000,
    S_CAP   = 7'b0010000,
    S_WR    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    PH_DIR  = 3'b001,
    PH_TBL  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NO_DIR = 3'd1;
  localparam logic [2:0] ST_NO_TBL = 3'd2;
  localparam logic [2:0] ST_RANGE  = 3'd3;
  localparam logic [2:0] ST_CROSS  = 3'd4;

  localparam logic CFG_PAGING   = 1'b0;
  localparam logic CFG_DIR_BASE = 1'b1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

endpackage

[hw/rtl/pmau_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module pmau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/paged_memory_access_unit.sv]
// Paged memory access unit: byte memory behind a two-level page walk.
// Depends on pmau_pkg and pmau_ram.
//
//   channel | handshake          | payload
//   cfg     | cfg_valid/ready    | cfg_index, cfg_data
//   in      | in_valid/in_ready  | op, vaddr, size_bytes, write_data
//   out     | out_valid/ready    | read_data, status
//
// The memory has one byte port; each byte read goes through S_RD and S_CAP, a write
// through S_WR. After S_DONE the unit returns to S_IDLE before taking the next item.
// Paging adds two 4-byte entry reads, directory then table; a page-crossing read
// repeats the walk per byte. A cross-page write goes straight to S_DONE with
// ST_CROSS and writes no byte; a fault also ends the item early.
// Reset clears control and config only; memory holds nothing until written.
// A finished item waits in the output register; the next item is taken meanwhile.
module paged_memory_access_unit
  import pmau_pkg::*;
#(
  parameter int MEM_BYTES = 262144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] vaddr,
  input  logic [2:0]  size_bytes,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic [2:0]  status
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [33:0] MEM_LIM = 34'(MEM_BYTES);

  state_t      state;
  phase_t      phase;
  logic        paging_enable;
  logic [19:0] dir_base_frame;

  logic        op_q;
  logic [31:0] va_q;
  logic [31:0] cur_va;
  logic [2:0]  n_q;
  logic [31:0] wd_q;
  logic        crosses_q;
  logic [31:0] pa;
  logic [AW-1:0] base;
  logic [1:0]  cnt;
  logic [2:0]  len;
  logic [1:0]  bi;
  logic [31:0] word;
  logic [31:0] acc;
  logic [2:0]  st;
  logic [31:0] res;

  logic [2:0]  n_in;
  logic [31:0] last_in;
  logic [31:0] word_next;
  logic [32:0] ent_dir;
  logic [32:0] ent_tbl;
  logic [2:0]  cnt_inc;
  logic [2:0]  bi_inc;
  logic [2:0]  chk_len;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  pmau_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    if (size_bytes == 3'd0) begin
      n_in = 3'd1;
    end else if (size_bytes > 3'd4) begin
      n_in = 3'd4;
    end else begin
      n_in = size_bytes;
    end
  end
  assign last_in = vaddr + {29'd0, n_in} - 32'd1;

  always_comb begin
    word_next = word;
    word_next[8*cnt +: 8] = mem_rdata;
  end

  assign ent_dir = {1'b0, dir_base_frame, 12'd0} + {21'd0, cur_va[31:22], 2'd0};
  assign ent_tbl = {1'b0, word_next[31:12], 12'd0} + {21'd0, cur_va[21:12], 2'd0};
  assign cnt_inc = {1'b0, cnt} + 3'd1;
  assign bi_inc  = {1'b0, bi} + 3'd1;
  assign chk_len = crosses_q ? 3'd1 : n_q;

  assign mem_addr  = base + AW'(cnt);
  assign mem_we    = (state == S_WR);
  assign mem_wdata = wd_q[8*cnt +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_DIR;
      paging_enable  <= 1'b0;
      dir_base_frame <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_PAGING) begin
          paging_enable <= cfg_data[0];
        end else begin
          dir_base_frame <= cfg_data[19:0];
        end
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q      <= op;
            va_q      <= vaddr;
            cur_va    <= vaddr;
            n_q       <= n_in;
            wd_q      <= write_data;
            crosses_q <= (last_in[31:12] != vaddr[31:12]);
            bi        <= '0;
            acc       <= '0;
            res       <= '0;
            if (op == OP_WRITE && last_in[31:12] != vaddr[31:12]) begin
              st    <= ST_CROSS;
              state <= S_DONE;
            end else begin
              state <= S_XLATE;
            end
          end
        end
        S_XLATE: begin
          if (!paging_enable) begin
            pa    <= cur_va;
            state <= S_CHECK;
          end else if ({1'b0, ent_dir} + 34'd4 > MEM_LIM) begin
            st    <= ST_RANGE;
            state <= S_DONE;
          end else begin
            base  <= ent_dir[AW-1:0];
            cnt   <= '0;
            len   <= 3'd4;
            word  <= '0;
            phase <= PH_DIR;
            state <= S_RD;
          end
        end
        S_CHECK: begin
          if ({2'b0, pa} + {31'd0, chk_len} > MEM_LIM) begin
            st    <= ST_RANGE;
            state <= S_DONE;
          end else begin
            base  <= pa[AW-1:0];
            cnt   <= '0;
            len   <= chk_len;
            word  <= '0;
            phase <= PH_DATA;
            state <= (op_q == OP_WRITE) ? S_WR : S_RD;
          end
        end
        S_RD: begin
          state <= S_CAP;
        end
        S_CAP: begin
          word <= word_next;
          cnt  <= cnt_inc[1:0];
          if (cnt_inc < len) begin
            state <= S_RD;
          end else begin
            case (phase)
              PH_DIR: begin
                if (!word_next[0]) begin
                  st    <= ST_NO_DIR;
                  state <= S_DONE;
                end else if ({1'b0, ent_tbl} + 34'd4 > MEM_LIM) begin
                  st    <= ST_RANGE;
                  state <= S_DONE;
                end else begin
                  base  <= ent_tbl[AW-1:0];
                  cnt   <= '0;
                  word  <= '0;
                  phase <= PH_TBL;
                  state <= S_RD;
                end
              end
              PH_TBL: begin
                if (!word_next[0]) begin
                  st    <= ST_NO_TBL;
                  state <= S_DONE;
                end else begin
                  pa    <= {word_next[31:12], cur_va[11:0]};
                  state <= S_CHECK;
                end
              end
              PH_DATA: begin
                if (crosses_q) begin
                  acc[8*bi +: 8] <= mem_rdata;
                  if (bi_inc == n_q) begin
                    res   <= acc | ({24'd0, mem_rdata} << (8 * bi));
                    st    <= ST_OK;
                    state <= S_DONE;
                  end else begin
                    bi     <= bi_inc[1:0];
                    cur_va <= va_q + {29'd0, bi_inc};
                    state  <= S_XLATE;
                  end
                end else begin
                  res   <= word_next;
                  st    <= ST_OK;
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_WR: begin
          cnt <= cnt_inc[1:0];
          if (cnt_inc >= len) begin
            st    <= ST_OK;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= st;
            read_data <= (st == ST_OK && op_q == OP_READ) ? res : 32'd0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
